/* design/md2_pkg.sv */
// ----------------------------------------------------------------------------
// md2_pkg
// Shared constants, sequencer states and the MD2 S permutation.
// ----------------------------------------------------------------------------
package md2_pkg;

    localparam int BLOCK_N  = 16;    // bytes per block / checksum length
    localparam int CHAIN_N  = 48;    // chain state bytes
    localparam int ROUNDS   = 18;    // mixing rounds per block
    localparam int SUM_BASE = 48;    // checksum entries follow the chain in RAM A
    localparam int A_DEPTH  = 64;
    localparam int A_AW     = $clog2(A_DEPTH);
    localparam int B_DEPTH  = 16;
    localparam int B_AW     = $clog2(B_DEPTH);
    localparam int RND_W    = $clog2(ROUNDS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_MIX1,
        ST_MIX2,
        ST_ROUND,
        ST_COPY,
        ST_WAIT_OUT,
        ST_READ_OUT
    } md2_state_t;

    localparam logic [7:0] SBOX [0:255] = '{
        8'd41,  8'd46,  8'd67,  8'd201, 8'd162, 8'd216, 8'd124, 8'd1,
        8'd61,  8'd54,  8'd84,  8'd161, 8'd236, 8'd240, 8'd6,   8'd19,
        8'd98,  8'd167, 8'd5,   8'd243, 8'd192, 8'd199, 8'd115, 8'd140,
        8'd152, 8'd147, 8'd43,  8'd217, 8'd188, 8'd76,  8'd130, 8'd202,
        8'd30,  8'd155, 8'd87,  8'd60,  8'd253, 8'd212, 8'd224, 8'd22,
        8'd103, 8'd66,  8'd111, 8'd24,  8'd138, 8'd23,  8'd229, 8'd18,
        8'd190, 8'd78,  8'd196, 8'd214, 8'd218, 8'd158, 8'd222, 8'd73,
        8'd160, 8'd251, 8'd245, 8'd142, 8'd187, 8'd47,  8'd238, 8'd122,
        8'd169, 8'd104, 8'd121, 8'd145, 8'd21,  8'd178, 8'd7,   8'd63,
        8'd148, 8'd194, 8'd16,  8'd137, 8'd11,  8'd34,  8'd95,  8'd33,
        8'd128, 8'd127, 8'd93,  8'd154, 8'd90,  8'd144, 8'd50,  8'd39,
        8'd53,  8'd62,  8'd204, 8'd231, 8'd191, 8'd247, 8'd151, 8'd3,
        8'd255, 8'd25,  8'd48,  8'd179, 8'd72,  8'd165, 8'd181, 8'd209,
        8'd215, 8'd94,  8'd146, 8'd42,  8'd172, 8'd86,  8'd170, 8'd198,
        8'd79,  8'd184, 8'd56,  8'd210, 8'd150, 8'd164, 8'd125, 8'd182,
        8'd118, 8'd252, 8'd107, 8'd226, 8'd156, 8'd116, 8'd4,   8'd241,
        8'd69,  8'd157, 8'd112, 8'd89,  8'd100, 8'd113, 8'd135, 8'd32,
        8'd134, 8'd91,  8'd207, 8'd101, 8'd230, 8'd45,  8'd168, 8'd2,
        8'd27,  8'd96,  8'd37,  8'd173, 8'd174, 8'd176, 8'd185, 8'd246,
        8'd28,  8'd70,  8'd97,  8'd105, 8'd52,  8'd64,  8'd126, 8'd15,
        8'd85,  8'd71,  8'd163, 8'd35,  8'd221, 8'd81,  8'd175, 8'd58,
        8'd195, 8'd92,  8'd249, 8'd206, 8'd186, 8'd197, 8'd234, 8'd38,
        8'd44,  8'd83,  8'd13,  8'd110, 8'd133, 8'd40,  8'd132, 8'd9,
        8'd211, 8'd223, 8'd205, 8'd244, 8'd65,  8'd129, 8'd77,  8'd82,
        8'd106, 8'd220, 8'd55,  8'd200, 8'd108, 8'd193, 8'd171, 8'd250,
        8'd36,  8'd225, 8'd123, 8'd8,   8'd12,  8'd189, 8'd177, 8'd74,
        8'd120, 8'd136, 8'd149, 8'd139, 8'd227, 8'd99,  8'd232, 8'd109,
        8'd233, 8'd203, 8'd213, 8'd254, 8'd59,  8'd0,   8'd29,  8'd57,
        8'd242, 8'd239, 8'd183, 8'd14,  8'd102, 8'd88,  8'd208, 8'd228,
        8'd166, 8'd119, 8'd114, 8'd248, 8'd235, 8'd117, 8'd75,  8'd10,
        8'd49,  8'd68,  8'd80,  8'd180, 8'd143, 8'd237, 8'd31,  8'd26,
        8'd219, 8'd153, 8'd141, 8'd51,  8'd159, 8'd17,  8'd131, 8'd20
    };

endpackage

/* design/md2_message_digest_top.sv */
// ----------------------------------------------------------------------------
// md2_message_digest_top
// MD2 hash engine: absorbs message bytes, emits the 128-bit digest on finish.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid/in_ready): each item carries mode and message_byte.
//   mode 0 absorbs message_byte; mode 1 pads and finishes the message.
//   Output channel (out_valid/out_ready): one item per finish, digest_hi holds
//   digest bytes 0..7 (byte 0 in the top bits), digest_lo bytes 8..15.
// Flow
//   An absorb item that does not complete a block leaves in_ready high.
//   The 16th byte of a block keeps in_ready low for the checksum walk, two
//   block load passes and 18 x 48 mixing steps.
//   A finish item compresses the pad block and then the checksum and reads
//   out the digest, then raises out_valid.
//   The rate is set by the read-modify-write loop on the chain RAM, which
//   handles one byte of state per cycle.
// Reset and stalls
//   Reset clears the chain and checksum (valid bits, no clearing pass) and the
//   fill count; after each digest the same state returns to zero.
//   The digest waits in its output register; the block keeps taking items
//   while it waits and stalls only if a second digest is ready before the
//   first has been taken.
// ----------------------------------------------------------------------------
module md2_message_digest_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        mode,
    input  logic [7:0]  message_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] digest_hi,
    output logic [63:0] digest_lo
);
    import md2_pkg::*;

    // Sequencer and control
    md2_state_t         state_reg, state_next;
    logic [A_AW-1:0]    idx_reg, idx_next;        // issue index
    logic [RND_W-1:0]   rnd_reg, rnd_next;        // issue round
    logic               iss_done_reg, iss_done_next;
    logic               s_vld_reg;                // read data stage
    logic               s_last_reg;
    logic               s_av_reg;                 // RAM A entry was written
    logic [A_AW-1:0]    s_idx_reg;
    logic [RND_W-1:0]   s_rnd_reg;
    logic [3:0]         fill_reg, fill_next;
    logic               fin_reg, fin_next;        // finishing a message
    logic               pad_en_reg, pad_en_next;  // block tail comes from padding
    logic [7:0]         sum_last_reg, sum_last_next;  // copy of checksum byte 15
    logic [A_DEPTH-1:0] a_valid_reg, a_valid_next;
    logic               out_valid_reg, out_valid_next;

    // Datapath
    logic [7:0]         t_reg, t_next;
    logic [63:0]        dhi_reg, dhi_next;
    logic [63:0]        dlo_reg, dlo_next;

    // RAM ports
    logic               a_we, b_we;
    logic [A_AW-1:0]    a_waddr, a_raddr;
    logic [B_AW-1:0]    b_waddr, b_raddr;
    logic [7:0]         a_wdata, b_wdata, a_rdata, b_rdata;

    // Stage signals
    logic               phase_act, iss, iss_last;
    logic [A_AW-1:0]    last_idx;
    logic [7:0]         ad, m, pad_val, s_in, s_out, mixed;
    logic               done;

    // Chain state in entries 0..47, checksum in 48..63
    md2_ram #(.WIDTH(8), .DEPTH(A_DEPTH)) u_ram_chain (
        .clk   (clk),
        .we    (a_we),
        .waddr (a_waddr),
        .wdata (a_wdata),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    // Pending message block
    md2_ram #(.WIDTH(8), .DEPTH(B_DEPTH)) u_ram_block (
        .clk   (clk),
        .we    (b_we),
        .waddr (b_waddr),
        .wdata (b_wdata),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign digest_hi = dhi_reg;
    assign digest_lo = dlo_reg;

    // Read issue: one address per cycle while a pass is running
    always_comb
    begin
        case (state_reg)
            ST_SUM, ST_MIX1, ST_MIX2, ST_ROUND, ST_COPY, ST_READ_OUT: phase_act = 1'b1;
            default:                                                   phase_act = 1'b0;
        endcase
    end

    assign last_idx = (state_reg == ST_ROUND) ? A_AW'(CHAIN_N - 1) : A_AW'(BLOCK_N - 1);
    assign iss      = phase_act && !iss_done_reg;
    assign iss_last = (idx_reg == last_idx) &&
                      ((state_reg != ST_ROUND) || (rnd_reg == RND_W'(ROUNDS - 1)));
    assign a_raddr  = ((state_reg == ST_SUM) || (state_reg == ST_COPY)) ?
                      (A_AW'(SUM_BASE) + idx_reg) : idx_reg;
    assign b_raddr  = idx_reg[B_AW-1:0];

    // Returned data; unwritten chain/checksum entries read as zero
    assign ad      = s_av_reg ? a_rdata : 8'h00;
    assign pad_val = 8'(BLOCK_N) - {4'b0000, fill_reg};
    assign m       = (pad_en_reg && (s_idx_reg[B_AW-1:0] >= fill_reg)) ? pad_val : b_rdata;
    assign s_in    = (state_reg == ST_SUM) ? (m ^ t_reg) : t_reg;
    assign s_out   = SBOX[s_in];
    assign mixed   = ad ^ s_out;
    assign done    = s_vld_reg && s_last_reg;

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        rnd_next       = rnd_reg;
        iss_done_next  = iss_done_reg;
        fill_next      = fill_reg;
        fin_next       = fin_reg;
        pad_en_next    = pad_en_reg;
        sum_last_next  = sum_last_reg;
        a_valid_next   = a_valid_reg;
        out_valid_next = out_valid_reg;
        t_next         = t_reg;
        dhi_next       = dhi_reg;
        dlo_next       = dlo_reg;
        a_we           = 1'b0;
        a_waddr        = s_idx_reg;
        a_wdata        = mixed;
        b_we           = 1'b0;
        b_waddr        = fill_reg;
        b_wdata        = message_byte;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (iss)
        begin
            if (idx_reg == last_idx)
            begin
                idx_next = '0;
                if (iss_last)
                begin
                    iss_done_next = 1'b1;
                end
                else
                begin
                    rnd_next = rnd_reg + 1'b1;
                end
            end
            else
            begin
                idx_next = idx_reg + 1'b1;
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    t_next = sum_last_reg;
                    if (mode)
                    begin
                        fin_next    = 1'b1;
                        pad_en_next = 1'b1;
                        state_next  = ST_SUM;
                    end
                    else
                    begin
                        b_we      = 1'b1;
                        fill_next = fill_reg + 1'b1;
                        if (fill_reg == 4'(BLOCK_N - 1))
                        begin
                            pad_en_next = 1'b0;
                            state_next  = ST_SUM;
                        end
                    end
                end
            end
            ST_SUM:
            begin
                // C[i] ^= S[M[i] ^ L], L follows the new byte
                if (s_vld_reg)
                begin
                    a_we    = 1'b1;
                    a_waddr = A_AW'(SUM_BASE) + s_idx_reg;
                    a_wdata = mixed;
                    t_next  = mixed;
                    if (s_idx_reg == A_AW'(BLOCK_N - 1))
                    begin
                        sum_last_next = mixed;
                    end
                end
                if (done)
                begin
                    state_next = ST_MIX1;
                end
            end
            ST_MIX1:
            begin
                if (s_vld_reg)
                begin
                    a_we    = 1'b1;
                    a_waddr = A_AW'(2 * BLOCK_N) + s_idx_reg;
                    a_wdata = ad ^ m;
                end
                if (done)
                begin
                    state_next = ST_MIX2;
                end
            end
            ST_MIX2:
            begin
                if (s_vld_reg)
                begin
                    a_we    = 1'b1;
                    a_waddr = A_AW'(BLOCK_N) + s_idx_reg;
                    a_wdata = m;
                end
                if (done)
                begin
                    t_next     = 8'h00;
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                if (s_vld_reg)
                begin
                    a_we    = 1'b1;
                    a_waddr = s_idx_reg;
                    a_wdata = mixed;
                    t_next  = (s_idx_reg == A_AW'(CHAIN_N - 1)) ?
                              (mixed + 8'(s_rnd_reg)) : mixed;
                end
                if (done)
                begin
                    if (!fin_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (pad_en_reg)
                    begin
                        state_next = ST_COPY;
                    end
                    else
                    begin
                        state_next = ST_WAIT_OUT;
                    end
                end
            end
            ST_COPY:
            begin
                // checksum becomes the last block
                if (s_vld_reg)
                begin
                    b_we    = 1'b1;
                    b_waddr = s_idx_reg[B_AW-1:0];
                    b_wdata = ad;
                end
                if (done)
                begin
                    pad_en_next = 1'b0;
                    state_next  = ST_MIX1;
                end
            end
            ST_WAIT_OUT:
            begin
                if (!out_valid_reg)
                begin
                    state_next = ST_READ_OUT;
                end
            end
            ST_READ_OUT:
            begin
                if (s_vld_reg)
                begin
                    dhi_next = {dhi_reg[55:0], dlo_reg[63:56]};
                    dlo_next = {dlo_reg[55:0], ad};
                end
                if (done)
                begin
                    out_valid_next = 1'b1;
                    a_valid_next   = '0;
                    fill_next      = 4'h0;
                    sum_last_next  = 8'h00;
                    fin_next       = 1'b0;
                    pad_en_next    = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (a_we)
        begin
            a_valid_next[a_waddr] = 1'b1;
        end

        if (done)
        begin
            idx_next      = '0;
            rnd_next      = '0;
            iss_done_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            rnd_reg       <= '0;
            iss_done_reg  <= 1'b0;
            s_vld_reg     <= 1'b0;
            s_last_reg    <= 1'b0;
            s_av_reg      <= 1'b0;
            fill_reg      <= 4'h0;
            fin_reg       <= 1'b0;
            pad_en_reg    <= 1'b0;
            sum_last_reg  <= 8'h00;
            a_valid_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            rnd_reg       <= rnd_next;
            iss_done_reg  <= iss_done_next;
            s_vld_reg     <= iss;
            s_last_reg    <= iss_last;
            s_av_reg      <= a_valid_reg[a_raddr];
            fill_reg      <= fill_next;
            fin_reg       <= fin_next;
            pad_en_reg    <= pad_en_next;
            sum_last_reg  <= sum_last_next;
            a_valid_reg   <= a_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_idx_reg <= idx_reg;
        s_rnd_reg <= rnd_reg;
        t_reg     <= t_next;
        dhi_reg   <= dhi_next;
        dlo_reg   <= dlo_next;
    end

endmodule

/* design/md2_ram.sv */
// ----------------------------------------------------------------------------
// md2_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module md2_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* design/md2_checker.sv */
// ----------------------------------------------------------------------------
// md2_checker
// Port-level checks on the MD2 engine, bound to the top level.
// ----------------------------------------------------------------------------
module md2_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        mode,
    input logic        out_valid,
    input logic        out_ready,
    input logic [63:0] digest_hi,
    input logic [63:0] digest_lo
);

    // stalled result item stays
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("out_valid dropped while stalled");

    // stalled digest holds
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(digest_hi) && $stable(digest_lo))
        else $error("digest changed while stalled");

    // a finish item starts the padding work at once
    a_finish_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && mode |=> !in_ready)
        else $error("input taken right after a finish item");

    // a digest appears only at the end of a busy stretch
    a_digest_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("digest raised while idle");

endmodule

bind md2_message_digest_top md2_checker u_md2_checker (.*);
